// ----- design/mesh_vertex_dedup_indexer_macros.svh -----
// assertion macros for the vertex dedup indexer
`ifndef MESH_VERTEX_DEDUP_INDEXER_MACROS_SVH
`define MESH_VERTEX_DEDUP_INDEXER_MACROS_SVH

// property must hold on every clock outside reset
`define MVDI_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define MVDI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/mvdi_pkg.sv -----
// ------------------------------------------------------------------
// mvdi_pkg
// types and helpers shared by the vertex dedup indexer
// ------------------------------------------------------------------
package mvdi_pkg;

    localparam int COMPONENTS = 8;
    localparam int VERTEX_W   = 32 * COMPONENTS;

    typedef struct packed {
        logic        new_mesh;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] vertex_index;
        logic       is_new;
        logic       table_full;
    } t_out_beat;

    // ieee single equality: signed zeros equal, nan never equal
    function automatic logic fp_equal(input logic [31:0] a, input logic [31:0] b);
        logic nan_a;
        logic nan_b;
        nan_a = (a[30:0] > 31'h7F80_0000);
        nan_b = (b[30:0] > 31'h7F80_0000);
        if (nan_a || nan_b) begin
            return 1'b0;
        end
        if ((a[30:0] | b[30:0]) == 31'd0) begin
            return 1'b1;
        end
        return a == b;
    endfunction

    function automatic logic vertex_equal(input logic [VERTEX_W-1:0] a,
                                          input logic [VERTEX_W-1:0] b);
        logic eq;
        eq = 1'b1;
        for (int k = 0; k < COMPONENTS; k++) begin
            eq = eq & fp_equal(a[k*32 +: 32], b[k*32 +: 32]);
        end
        return eq;
    endfunction

endpackage

// ----- design/mvdi_cell.sv -----
// ------------------------------------------------------------------
// mvdi_cell
// one table entry; compares the passing corner and hands it on
// ------------------------------------------------------------------
module mvdi_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_clear,
    input  logic                           i_done,
    input  logic [mvdi_pkg::VERTEX_W-1:0]  i_vtx,
    output logic                           o_valid,
    output logic                           o_clear,
    output logic                           o_done,
    output logic [mvdi_pkg::VERTEX_W-1:0]  o_vtx,
    output logic                           o_hit,
    output logic                           o_store
);
    logic                          r_used;
    logic [mvdi_pkg::VERTEX_W-1:0] r_entry;
    logic                          r_valid, r_clear, r_done;
    logic [mvdi_pkg::VERTEX_W-1:0] r_vtx;
    logic                          used_now, hit, store;

    // a clear at this cell empties it before the compare
    assign used_now = r_used && !i_clear;
    assign hit      = i_valid && !i_done && used_now
                      && mvdi_pkg::vertex_equal(r_entry, i_vtx);
    assign store    = i_valid && !i_done && !used_now;
    assign o_hit    = hit;
    assign o_store  = store;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (store) begin
            r_used <= 1'b1;
        end else if (i_valid && i_clear) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_entry <= i_vtx;
        end
    end

    // forward to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_clear <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= i_valid;
            r_clear <= i_valid && i_clear;
            r_done  <= i_valid && (i_done || hit || store);
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx <= i_vtx;
    end

    assign o_valid = r_valid;
    assign o_clear = r_clear;
    assign o_done  = r_done;
    assign o_vtx   = r_vtx;
endmodule

// ----- design/mesh_vertex_dedup_indexer.sv -----
// ------------------------------------------------------------------
// mesh_vertex_dedup_indexer
// vertex dedup index buffer built as a chain of table cells
// ------------------------------------------------------------------
// channel | dir | handshake           | payload
// in      | in  | i_in_valid/o_in_ready | mvdi_pkg::t_in_beat
// out     | out | o_out_valid/i_out_ready | mvdi_pkg::t_out_beat
// one corner at a time; it is registered, then walks the cell chain one
// cell a cycle, and once it has passed the last cell the result is
// registered in the output register; no new beat is taken before then
// synchronous active-low reset empties the table
// the input is not taken while a result waits in the output register
`include "mesh_vertex_dedup_indexer_macros.svh"
module mesh_vertex_dedup_indexer #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mvdi_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mvdi_pkg::t_out_beat  o_out_data
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic                          c_valid [TABLE_ENTRIES+1];
    logic                          c_clear [TABLE_ENTRIES+1];
    logic                          c_done  [TABLE_ENTRIES+1];
    logic [mvdi_pkg::VERTEX_W-1:0] c_vtx   [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0]      hit_v, store_v;

    logic                r_busy, n_busy;
    logic                r_out_valid;
    mvdi_pkg::t_out_beat r_out, n_out;
    logic [IW-1:0]       r_pos, n_pos;
    logic                r_found, n_found;
    logic                r_in_valid;
    mvdi_pkg::t_in_beat  r_in_beat;
    logic                in_fire, out_fire;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign o_in_ready = !r_busy && !r_out_valid;

    // accepted beat enters the chain in the cycle after it is taken, in step with r_pos
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_beat <= i_in_data;
        end
    end

    assign c_valid[0] = r_in_valid;
    assign c_clear[0] = r_in_beat.new_mesh;
    assign c_done[0]  = 1'b0;
    assign c_vtx[0]   = {r_in_beat.pos_x, r_in_beat.pos_y, r_in_beat.pos_z,
                         r_in_beat.norm_x, r_in_beat.norm_y, r_in_beat.norm_z,
                         r_in_beat.tex_u, r_in_beat.tex_v};

    // the cell chain
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        mvdi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_clear (c_clear[g]),
            .i_done  (c_done[g]),
            .i_vtx   (c_vtx[g]),
            .o_valid (c_valid[g+1]),
            .o_clear (c_clear[g+1]),
            .o_done  (c_done[g+1]),
            .o_vtx   (c_vtx[g+1]),
            .o_hit   (hit_v[g]),
            .o_store (store_v[g])
        );
    end

    // track the beat position and capture the first hit or store, else flag the table full
    always_comb begin
        n_busy  = r_busy;
        n_pos   = r_pos;
        n_found = r_found;
        n_out   = r_out;
        if (in_fire) begin
            n_busy  = 1'b1;
            n_pos   = '0;
            n_found = 1'b0;
        end else if (r_busy) begin
            if (!r_found && (hit_v[r_pos] || store_v[r_pos])) begin
                n_found            = 1'b1;
                n_out.vertex_index = 8'(r_pos);
                n_out.is_new       = store_v[r_pos];
                n_out.table_full   = 1'b0;
            end
            if (r_pos == IW'(TABLE_ENTRIES - 1)) begin
                n_busy = 1'b0;
                if (!n_found) begin
                    n_out.vertex_index = '0;
                    n_out.is_new       = 1'b0;
                    n_out.table_full   = 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_found <= n_found;
            r_pos   <= n_pos;
            if (r_busy && !n_busy) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MVDI_ASSERT(a_no_busy_and_out, !(r_busy && r_out_valid))
    `MVDI_ASSERT(a_one_event, $onehot0(hit_v | store_v))
    `MVDI_ASSERT_NEXT(a_flag_excl, r_out_valid, !(r_out.is_new && r_out.table_full))
endmodule
